// ===== sv/tao_pkg.sv =====
// ----------------------------------------------------------------------------
// tao_pkg
// Shared widths, register indexes, reset values and types for the
// transformed bounding box overlap block.
// ----------------------------------------------------------------------------
`default_nettype none

package tao_pkg;

   localparam int COORD_W   = 16;                 // coordinate and register width
   localparam int FRAC_BITS = 12;                 // Q4.12
   localparam int PROD_W    = 2 * COORD_W;        // one product
   localparam int SUM_W     = PROD_W + 1;         // sum of two products
   localparam int SHIFT_W   = SUM_W - FRAC_BITS;  // after the fraction shift
   localparam int ACC_W     = SHIFT_W + 1;        // after the translation add

   localparam int CSR_COUNT  = 8;
   localparam int CSR_ADDR_W = $clog2(CSR_COUNT);

   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_ROT_COS  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_ROT_SIN  = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_SHIFT_X  = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_SHIFT_Y  = CSR_ADDR_W'(3);
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_ROT_COS = CSR_ADDR_W'(4);
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_ROT_SIN = CSR_ADDR_W'(5);
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_SHIFT_X = CSR_ADDR_W'(6);
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_SHIFT_Y = CSR_ADDR_W'(7);

   // unit scale, no rotation, at the origin
   localparam logic [COORD_W-1:0] ROT_COS_RESET = COORD_W'(1 << FRAC_BITS);
   localparam logic [COORD_W-1:0] ZERO_RESET    = '0;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   localparam int REQ_DATA_W = 2 * COORD_W;
   localparam int RSP_DATA_W = 8;

   // one mapped vertex on its way to the box tracker
   typedef struct packed {
      logic                      obj;
      logic                      last;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

endpackage

`default_nettype wire

// ===== sv/tao_transform.sv =====
// ----------------------------------------------------------------------------
// tao_transform
// Holds the per-object map registers and maps local vertices to world
// coordinates: input register, product register, saturated point register.
// ----------------------------------------------------------------------------
`default_nettype none

module tao_transform
   import tao_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration writes
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_ADDR_W-1:0]     csr_index,
   input  wire logic [COORD_W-1:0]        csr_wdata,
   // vertex requests
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_obj,
   input  wire logic                      req_last,
   input  wire logic signed [COORD_W-1:0] req_x,
   input  wire logic signed [COORD_W-1:0] req_y,
   // mapped points
   output logic                           pt_valid,
   input  wire logic                      pt_ready,
   output point_type                      pt
);

   logic [COORD_W-1:0] cfg_ff [CSR_COUNT];

   // stage 1: input register
   logic                      s1_valid_ff;
   logic                      s1_obj_ff;
   logic                      s1_last_ff;
   logic signed [COORD_W-1:0] s1_x_ff;
   logic signed [COORD_W-1:0] s1_y_ff;
   logic                      s1_ready;

   // stage 2: products
   logic                      s2_valid_ff;
   logic                      s2_obj_ff;
   logic                      s2_last_ff;
   logic signed [PROD_W-1:0]  s2_ax_ff;
   logic signed [PROD_W-1:0]  s2_by_ff;
   logic signed [PROD_W-1:0]  s2_bx_ff;
   logic signed [PROD_W-1:0]  s2_ay_ff;
   logic signed [COORD_W-1:0] s2_tx_ff;
   logic signed [COORD_W-1:0] s2_ty_ff;
   logic                      s2_ready;

   // stage 3: mapped point
   logic                      s3_valid_ff;
   point_type                 s3_pt_ff;
   point_type                 s3_pt_in;
   logic                      s3_ready;

   logic signed [COORD_W-1:0] sel_a;
   logic signed [COORD_W-1:0] sel_b;
   logic signed [COORD_W-1:0] sel_tx;
   logic signed [COORD_W-1:0] sel_ty;
   logic signed [SUM_W-1:0]   sum_x;
   logic signed [SUM_W-1:0]   sum_y;
   logic signed [ACC_W-1:0]   acc_x;
   logic signed [ACC_W-1:0]   acc_y;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &v[ACC_W-1:COORD_W-1];
      hi_zeros = ~|v[ACC_W-1:COORD_W-1];
      if (hi_ones || hi_zeros) begin
         sat_coord = v[COORD_W-1:0];
      end else if (v[ACC_W-1]) begin
         sat_coord = COORD_MIN;
      end else begin
         sat_coord = COORD_MAX;
      end
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_FIRST_ROT_COS]  <= ROT_COS_RESET;
         cfg_ff[CSR_FIRST_ROT_SIN]  <= ZERO_RESET;
         cfg_ff[CSR_FIRST_SHIFT_X]  <= ZERO_RESET;
         cfg_ff[CSR_FIRST_SHIFT_Y]  <= ZERO_RESET;
         cfg_ff[CSR_SECOND_ROT_COS] <= ROT_COS_RESET;
         cfg_ff[CSR_SECOND_ROT_SIN] <= ZERO_RESET;
         cfg_ff[CSR_SECOND_SHIFT_X] <= ZERO_RESET;
         cfg_ff[CSR_SECOND_SHIFT_Y] <= ZERO_RESET;
      end else if (csr_wr_en) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // each stage moves when it is empty or the next one takes its item
   assign s3_ready  = !s3_valid_ff || pt_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_obj_ff  <= req_obj;
         s1_last_ff <= req_last;
         s1_x_ff    <= req_x;
         s1_y_ff    <= req_y;
      end
   end

   always_comb begin
      if (s1_obj_ff) begin
         sel_a  = cfg_ff[CSR_SECOND_ROT_COS];
         sel_b  = cfg_ff[CSR_SECOND_ROT_SIN];
         sel_tx = cfg_ff[CSR_SECOND_SHIFT_X];
         sel_ty = cfg_ff[CSR_SECOND_SHIFT_Y];
      end else begin
         sel_a  = cfg_ff[CSR_FIRST_ROT_COS];
         sel_b  = cfg_ff[CSR_FIRST_ROT_SIN];
         sel_tx = cfg_ff[CSR_FIRST_SHIFT_X];
         sel_ty = cfg_ff[CSR_FIRST_SHIFT_Y];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_obj_ff  <= s1_obj_ff;
         s2_last_ff <= s1_last_ff;
         s2_ax_ff   <= sel_a * s1_x_ff;
         s2_by_ff   <= sel_b * s1_y_ff;
         s2_bx_ff   <= sel_b * s1_x_ff;
         s2_ay_ff   <= sel_a * s1_y_ff;
         s2_tx_ff   <= sel_tx;
         s2_ty_ff   <= sel_ty;
      end
   end

   // arithmetic shift of the signed sum is a floor shift
   always_comb begin
      sum_x = SUM_W'(s2_ax_ff) - SUM_W'(s2_by_ff);
      sum_y = SUM_W'(s2_bx_ff) + SUM_W'(s2_ay_ff);
      acc_x = ACC_W'(sum_x >>> FRAC_BITS) + ACC_W'(s2_tx_ff);
      acc_y = ACC_W'(sum_y >>> FRAC_BITS) + ACC_W'(s2_ty_ff);
      s3_pt_in.obj  = s2_obj_ff;
      s3_pt_in.last = s2_last_ff;
      s3_pt_in.x    = sat_coord(acc_x);
      s3_pt_in.y    = sat_coord(acc_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_pt_ff <= s3_pt_in;
      end
   end

   assign pt_valid = s3_valid_ff;
   assign pt       = s3_pt_ff;

endmodule

`default_nettype wire

// ===== sv/tao_box.sv =====
// ----------------------------------------------------------------------------
// tao_box
// Running min/max box per object, the four-end interval test on the last
// vertex of a query, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tao_box
   import tao_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // mapped points
   input  wire logic       pt_valid,
   output logic            pt_ready,
   input  wire point_type  pt,
   // results
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_collide,
   output logic            rsp_overlap_x,
   output logic            rsp_overlap_y
);

   logic signed [COORD_W-1:0] min_x_ff [2];
   logic signed [COORD_W-1:0] max_x_ff [2];
   logic signed [COORD_W-1:0] min_y_ff [2];
   logic signed [COORD_W-1:0] max_y_ff [2];
   logic                      seen_ff  [2];

   logic signed [COORD_W-1:0] min_x_in [2];
   logic signed [COORD_W-1:0] max_x_in [2];
   logic signed [COORD_W-1:0] min_y_in [2];
   logic signed [COORD_W-1:0] max_y_in [2];
   logic                      seen_in  [2];

   logic rsp_valid_ff;
   logic collide_ff;
   logic overlap_x_ff;
   logic overlap_y_ff;

   logic out_ready;
   logic take;
   logic both_seen;
   logic meet_x;
   logic meet_y;

   function automatic logic ends_meet(input logic signed [COORD_W-1:0] min1,
                                      input logic signed [COORD_W-1:0] max1,
                                      input logic signed [COORD_W-1:0] min2,
                                      input logic signed [COORD_W-1:0] max2);
      ends_meet = (min2 >= min1 && min2 <= max1) || (max2 >= min1 && max2 <= max1) ||
                  (min1 >= min2 && min1 <= max2) || (max1 >= min2 && max1 <= max2);
   endfunction

   assign out_ready = !rsp_valid_ff || rsp_ready;
   // a non-final point never waits on the result register
   assign take      = pt_valid && (!pt.last || out_ready);
   assign pt_ready  = !pt.last || out_ready;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         min_x_in[k] = min_x_ff[k];
         max_x_in[k] = max_x_ff[k];
         min_y_in[k] = min_y_ff[k];
         max_y_in[k] = max_y_ff[k];
         seen_in[k]  = seen_ff[k];
         if (pt.obj == k[0]) begin
            if (pt.x < min_x_ff[k]) min_x_in[k] = pt.x;
            if (pt.x > max_x_ff[k]) max_x_in[k] = pt.x;
            if (pt.y < min_y_ff[k]) min_y_in[k] = pt.y;
            if (pt.y > max_y_ff[k]) max_y_in[k] = pt.y;
            seen_in[k] = 1'b1;
         end
      end
      both_seen = seen_in[0] && seen_in[1];
      meet_x = both_seen && ends_meet(min_x_in[0], max_x_in[0], min_x_in[1], max_x_in[1]);
      meet_y = both_seen && ends_meet(min_y_in[0], max_y_in[0], min_y_in[1], max_y_in[1]);
   end

   always_ff @(posedge clock) begin
      if (reset || (take && pt.last)) begin
         for (int k = 0; k < 2; k++) begin
            min_x_ff[k] <= COORD_MAX;
            max_x_ff[k] <= COORD_MIN;
            min_y_ff[k] <= COORD_MAX;
            max_y_ff[k] <= COORD_MIN;
            seen_ff[k]  <= 1'b0;
         end
      end else if (take) begin
         for (int k = 0; k < 2; k++) begin
            min_x_ff[k] <= min_x_in[k];
            max_x_ff[k] <= max_x_in[k];
            min_y_ff[k] <= min_y_in[k];
            max_y_ff[k] <= max_y_in[k];
            seen_ff[k]  <= seen_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && pt.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pt.last) begin
         collide_ff   <= meet_x && meet_y;
         overlap_x_ff <= meet_x;
         overlap_y_ff <= meet_y;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_collide   = collide_ff;
   assign rsp_overlap_x = overlap_x_ff;
   assign rsp_overlap_y = overlap_y_ff;

endmodule

`default_nettype wire

// ===== sv/transformed_aabb_overlap_top.sv =====
// ----------------------------------------------------------------------------
// transformed_aabb_overlap_top
// Maps 2D vertices of two objects by per-object rotate-scale-translate maps
// and reports whether the bounding boxes of the two objects overlap.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one local vertex per transfer; tuser picks the object,
//   tlast marks the last vertex of a query. Only the last vertex produces a
//   response on rsp_*: collide, overlap_x and overlap_y.
//   csr_* writes the map registers (cos, sin, shift x, shift y for object 0,
//   then object 1); write only while no query is in flight.
// Response path: the last vertex passes the input, product and point
//   registers, then the result register.
// Throughput: one vertex per cycle while no stall holds the pipeline, set
//   by the four 16x16 multipliers that work in parallel in the product stage.
// Reset: clears the pipeline and both boxes and loads unit scale, no
//   rotation, zero shift for both objects; req_tready is high right after.
// Stall: while a response waits on rsp_tready, vertices keep flowing into
//   the boxes; a later last vertex waits in the pipeline, which then fills
//   and drops req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module transformed_aabb_overlap_top
   import tao_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // configuration
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [COORD_W-1:0]      csr_wdata,
   // vertex requests
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,  // vert_x, vert_y
   input  wire logic                    req_tuser,  // which_object
   input  wire logic                    req_tlast,  // final_vertex
   // responses
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata   // collide, overlap_x, overlap_y, zeros
);

   logic      pt_valid;
   logic      pt_ready;
   point_type pt;
   logic      collide;
   logic      overlap_x;
   logic      overlap_y;

   tao_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_obj   (req_tuser),
      .req_last  (req_tlast),
      .req_x     (req_tdata[COORD_W-1:0]),
      .req_y     (req_tdata[2*COORD_W-1:COORD_W]),
      .pt_valid  (pt_valid),
      .pt_ready  (pt_ready),
      .pt        (pt)
   );

   tao_box u_box (
      .clock         (clock),
      .reset         (reset),
      .pt_valid      (pt_valid),
      .pt_ready      (pt_ready),
      .pt            (pt),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_collide   (collide),
      .rsp_overlap_x (overlap_x),
      .rsp_overlap_y (overlap_y)
   );

   assign rsp_tdata = {(RSP_DATA_W-3)'(0), overlap_y, overlap_x, collide};

endmodule

`default_nettype wire

// ===== sv/tao_checker.sv =====
// ----------------------------------------------------------------------------
// tao_checker
// Port-level checks on the overlap block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tao_checker
   import tao_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   default clocking cb @(posedge clock);
   endclocking

   // a stalled response is held
   a_rsp_hold: assert property (disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_collide: assert property (disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[1] && rsp_tdata[2]))
      else $error("collide differs from overlap_x and overlap_y");

   a_pad_zero: assert property (disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:3] == '0)
      else $error("response padding bits not zero");

   // reset empties the pipeline
   a_reset_empty: assert property (disable iff (reset)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

bind transformed_aabb_overlap_top tao_checker u_tao_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
